// ----- hw/rtl/mi3_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 matrix inverse unit.
// No dependencies; used by the divider array and the top level.
package mi3_pkg;

  // Number of matrix entries, i.e. divider lanes.
  localparam int unsigned NumLanes = 9;
  // Quotient bits produced by the divider (one per pipeline stage).
  localparam int unsigned QuotBits = 32;
  // Total scale shift: input frac bits plus output frac bits.
  localparam int unsigned ScaleShift = 12 + 16;
  // Numerator bits fed in during the divide (cofactor bits below the shift).
  localparam int unsigned PreBits = QuotBits - ScaleShift;
  // Width of the determinant magnitude.
  localparam int unsigned DetWidth = 49;

  // Per-request sideband that travels alongside the divider lanes.
  typedef struct packed {
    logic                valid;
    logic                singular;
    logic [NumLanes-1:0] neg;
    logic [NumLanes-1:0] ovf;
  } mi3_side_t;

endpackage

// ----- hw/rtl/mi3_divider.sv -----
`timescale 1ns / 1ps
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// Depends on mi3_pkg for lane count, widths and the sideband type.
module mi3_divider import mi3_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  mi3_side_t           side_i,
  input  logic [DetWidth-1:0] den_i,
  input  logic [DetWidth-1:0] rem_i [NumLanes],
  input  logic [PreBits-1:0]  num_i [NumLanes],
  output mi3_side_t           side_o,
  output logic [QuotBits-1:0] quot_o [NumLanes]
);

  mi3_side_t           side_q [QuotBits];
  mi3_side_t           side_d [QuotBits];
  logic [DetWidth-1:0] den_q  [QuotBits];
  logic [DetWidth-1:0] den_d  [QuotBits];
  logic [DetWidth-1:0] rem_q  [QuotBits][NumLanes];
  logic [DetWidth-1:0] rem_d  [QuotBits][NumLanes];
  logic [PreBits-1:0]  num_q  [QuotBits][NumLanes];
  logic [PreBits-1:0]  num_d  [QuotBits][NumLanes];
  logic [QuotBits-1:0] quot_q [QuotBits][NumLanes];
  logic [QuotBits-1:0] quot_d [QuotBits][NumLanes];

  // One compare/subtract per lane per stage
  always_comb begin
    logic [DetWidth-1:0] rp;
    logic [DetWidth-1:0] dp;
    logic [PreBits-1:0]  np;
    logic [QuotBits-1:0] qp;
    logic [DetWidth:0]   t;
    for (int s = 0; s < QuotBits; s++) begin
      dp        = (s == 0) ? den_i : den_q[s-1];
      side_d[s] = (s == 0) ? side_i : side_q[s-1];
      den_d[s]  = dp;
      for (int l = 0; l < NumLanes; l++) begin
        rp = (s == 0) ? rem_i[l] : rem_q[s-1][l];
        np = (s == 0) ? num_i[l] : num_q[s-1][l];
        qp = (s == 0) ? '0 : quot_q[s-1][l];
        t  = {rp, np[PreBits-1]};
        num_d[s][l] = np << 1;
        if (t >= {1'b0, dp}) begin
          rem_d[s][l]  = DetWidth'(t - {1'b0, dp});
          quot_d[s][l] = {qp[QuotBits-2:0], 1'b1};
        end else begin
          rem_d[s][l]  = DetWidth'(t);
          quot_d[s][l] = {qp[QuotBits-2:0], 1'b0};
        end
      end
    end
  end

  // Sideband and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < QuotBits; s++) side_q[s] <= '0;
    end else if (en_i) begin
      for (int s = 0; s < QuotBits; s++) side_q[s] <= side_d[s];
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= den_d;
      rem_q  <= rem_d;
      num_q  <= num_d;
      quot_q <= quot_d;
    end
  end

  assign side_o = side_q[QuotBits-1];
  always_comb begin
    for (int l = 0; l < NumLanes; l++) quot_o[l] = quot_q[QuotBits-1][l];
  end

endmodule

// ----- hw/rtl/matrix_inverse_3x3_unit.sv -----
`timescale 1ns / 1ps
// Top level of the 3x3 matrix inverse (adjugate / determinant) unit.
// Depends on mi3_pkg and mi3_divider.
//
//  Channel | Direction | Contents
//  s_axis  | in        | tdata: m00..m22, 16-bit Q4.12 each
//  m_axis  | out       | tdata: r00..r22, 32-bit Q16.16; tuser: singular, saturated
//
// The pipeline has 7 front stages (input, products, cofactors, det products,
// det sum, magnitudes, overflow check), 32 divider stages and 1 output stage.
// One request per cycle; the whole pipeline advances on a single enable,
// which is low only while a result waits at the output and is not taken.
// Reset clears the valid bits and the divider sideband registers only.
module matrix_inverse_3x3_unit import mi3_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22
  output logic [1:0]   m_axis_tuser    // singular, saturated
);

  // Minor operand indices: cof = a[PA]*a[PB] - a[PC]*a[PD]
  localparam int PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int PC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int PD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic en;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vo_q;

  logic signed [15:0] a_q    [9];
  logic signed [31:0] p_q    [18];
  logic signed [15:0] row1_q [3];
  logic signed [15:0] row2_q [3];
  logic signed [32:0] cof2_q [9];
  logic signed [32:0] cof3_q [9];
  logic signed [32:0] cof4_q [9];
  logic signed [48:0] dp_q   [3];
  logic signed [50:0] det_q;

  logic [DetWidth-1:0] dmag5_q;
  logic                dneg5_q;
  logic                sing5_q;
  logic [31:0]         cmag5_q [9];
  logic [8:0]          cneg5_q;

  logic                sing6_q;
  logic [NumLanes-1:0] neg6_q;
  logic [NumLanes-1:0] ovf6_q;
  mi3_side_t           side6;
  logic [DetWidth-1:0] den6_q;
  logic [DetWidth-1:0] rem6_q [NumLanes];
  logic [PreBits-1:0]  num6_q [NumLanes];

  mi3_side_t           side_dv;
  logic [QuotBits-1:0] quot_dv [NumLanes];

  logic [31:0] res_d [9];
  logic [31:0] res_q [9];
  logic        sat_d, sat_q, sing_q;

  // Global stall: advance unless a result is held at the output
  assign en            = !vo_q || m_axis_tready;
  assign s_axis_tready = en;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0; vo_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vo_q <= side_dv.valid;
    end
  end

  // Front-end arithmetic stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      // input capture
      for (int i = 0; i < 9; i++) a_q[i] <= s_axis_tdata[i*16 +: 16];
      // minor products
      for (int c = 0; c < 9; c++) begin
        p_q[2*c]   <= a_q[PA[c]] * a_q[PB[c]];
        p_q[2*c+1] <= a_q[PC[c]] * a_q[PD[c]];
      end
      for (int i = 0; i < 3; i++) begin
        row1_q[i] <= a_q[i];
        row2_q[i] <= row1_q[i];
      end
      // cofactors
      for (int c = 0; c < 9; c++) cof2_q[c] <= 33'(p_q[2*c]) - 33'(p_q[2*c+1]);
      // determinant terms along row 0
      for (int i = 0; i < 3; i++) dp_q[i] <= 49'(row2_q[i]) * 49'(cof2_q[3*i]);
      cof3_q <= cof2_q;
      // determinant sum
      det_q  <= 51'(dp_q[0]) + 51'(dp_q[1]) + 51'(dp_q[2]);
      cof4_q <= cof3_q;
      // magnitudes and signs
      dneg5_q <= det_q < 0;
      sing5_q <= det_q == '0;
      dmag5_q <= DetWidth'((det_q < 0) ? -det_q : det_q);
      for (int c = 0; c < 9; c++) begin
        cneg5_q[c] <= cof4_q[c] < 0;
        cmag5_q[c] <= 32'((cof4_q[c] < 0) ? -cof4_q[c] : cof4_q[c]);
      end
      // quotient range check and divider seed
      den6_q <= dmag5_q;
      for (int c = 0; c < 9; c++) begin
        neg6_q[c] <= cneg5_q[c] ^ dneg5_q;
        ovf6_q[c] <= (DetWidth+PreBits)'(cmag5_q[c]) >= {dmag5_q, {PreBits{1'b0}}};
        rem6_q[c] <= DetWidth'(cmag5_q[c] >> PreBits);
        num6_q[c] <= cmag5_q[c][PreBits-1:0];
      end
      sing6_q <= sing5_q;
      // output register
      res_q  <= res_d;
      sat_q  <= sat_d;
      sing_q <= side_dv.singular;
    end
  end

  // Sideband into the divider: valid bit plus per-lane flags
  always_comb begin
    side6.valid    = v6_q;
    side6.singular = sing6_q;
    side6.neg      = neg6_q;
    side6.ovf      = ovf6_q;
  end

  mi3_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side6),
    .den_i  (den6_q),
    .rem_i  (rem6_q),
    .num_i  (num6_q),
    .side_o (side_dv),
    .quot_o (quot_dv)
  );

  // Sign, saturation and singular override
  always_comb begin
    logic [31:0] q;
    logic        ng;
    logic        ov;
    sat_d = 1'b0;
    for (int l = 0; l < 9; l++) begin
      q  = quot_dv[l];
      ng = side_dv.neg[l];
      ov = side_dv.ovf[l] || (ng ? (q[31] && (|q[30:0])) : q[31]);
      if (side_dv.singular) begin
        res_d[l] = '0;
      end else if (ov) begin
        res_d[l] = ng ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat_d    = 1'b1;
      end else begin
        res_d[l] = ng ? -q : q;
      end
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tuser  = {sat_q, sing_q};
  always_comb begin
    for (int l = 0; l < 9; l++) m_axis_tdata[l*32 +: 32] = res_q[l];
  end

  // A singular result carries zero entries and no saturation
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("singular result with nonzero payload");

  // Input side is ready exactly when the pipeline can advance
  a_ready_eq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("tready does not follow pipeline enable");

  // A stall freezes the front-end valid bits
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v0_q) && $stable(v3_q) && $stable(v6_q)))
    else $error("pipeline moved during stall");

endmodule
